/* hw/rtl/pcmpwm_pkg.sv */
// ----------------------------------------------------------------------------
// pcmpwm_pkg
// Shared sizes and item types for the PCM block ring to PWM duty block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcmpwm_pkg;

  localparam int RING_BLOCKS   = 4;
  localparam int BLOCK_SAMPLES = 256;
  localparam int DUTY_BITS     = 11;

  localparam int RING_ENTRIES = RING_BLOCKS * BLOCK_SAMPLES;
  localparam int ADDR_W       = $clog2(RING_ENTRIES);
  localparam int BLK_W        = (RING_BLOCKS > 1) ? $clog2(RING_BLOCKS) : 1;
  localparam int POS_W        = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
  localparam int CNT_W        = $clog2(RING_BLOCKS + 1);

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic                 write_accepted;
    logic [DUTY_BITS-1:0] duty;
    logic                 duty_valid;
    logic                 block_done;
    logic [15:0]          underrun_count;
    logic [2:0]           ready_blocks;
  } out_item_t;

endpackage

/* hw/rtl/pcm_block_ring_to_pwm_duty.sv */
// ----------------------------------------------------------------------------
// pcm_block_ring_to_pwm_duty: PCM sample block ring feeding a PWM duty value.
// An accepted item is held in stage 1 while its ring read is in flight, then
// moves into the output register on out_data once that register is free.
// Throughput: one item per cycle while out_ready stays high; set by the one
// ring memory port pair and the single read-data stage. Sync reset, no sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcm_block_ring_to_pwm_duty (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pcmpwm_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pcmpwm_pkg::out_item_t out_data,
  input  logic                  cfg_we,
  input  logic [3:0]            cfg_wdata
);

  import pcmpwm_pkg::*;

  // Stage 1 holds an item while its ring read is in flight. Everything but
  // the duty is settled at accept time; the duty needs the read data.
  typedef struct packed {
    logic        mode;
    logic        hit;        // tick found a ready block
    logic        wr_ok;
    logic        done;
    logic [15:0] underrun;
    logic [2:0]  ready;
  } s1_t;

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  logic [BLK_W-1:0]  wr_blk_r, wr_blk_nxt;
  logic [BLK_W-1:0]  rd_blk_r, rd_blk_nxt;
  logic [POS_W-1:0]  wr_pos_r, wr_pos_nxt;
  logic [POS_W-1:0]  rd_pos_r, rd_pos_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [15:0]       underrun_r, underrun_nxt;
  logic [3:0]        gain_r;

  logic              s1_valid_r;
  s1_t               s1_r, s1_nxt;
  logic              out_valid_r;
  out_item_t         out_r;

  logic              accept;
  logic              out_free;
  logic              is_push;
  logic              is_tick;
  logic              ring_full;
  logic              ring_empty;
  logic              do_write;
  logic              do_read;
  logic              wr_last;
  logic              rd_last;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [2:0]        cnt_ext;

  // Ring memory: one write port, one registered read port.
  logic [15:0]       ring_mem [RING_ENTRIES];
  logic [15:0]       rd_data_r;

  // The output register frees up when empty or when its item is taken;
  // stage 1 then drains into it, so a new item may enter the same cycle.
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || out_free;
  assign accept   = in_valid && in_ready;

  assign is_push    = (in_data.mode == MODE_PUSH);
  assign is_tick    = (in_data.mode == MODE_TICK);
  assign ring_full  = (cnt_r == CNT_W'(RING_BLOCKS));
  assign ring_empty = (cnt_r == '0);
  assign do_write   = accept && is_push && !ring_full;
  assign do_read    = accept && is_tick && !ring_empty;
  assign wr_last    = (wr_pos_r == POS_W'(BLOCK_SAMPLES - 1));
  assign rd_last    = (rd_pos_r == POS_W'(BLOCK_SAMPLES - 1));

  // Block base is a multiply by a constant; a shift when the size is 2^n.
  assign wr_addr = ADDR_W'(ADDR_W'(wr_blk_r) * ADDR_W'(BLOCK_SAMPLES) + ADDR_W'(wr_pos_r));
  assign rd_addr = ADDR_W'(ADDR_W'(rd_blk_r) * ADDR_W'(BLOCK_SAMPLES) + ADDR_W'(rd_pos_r));

  // --------------------------------------------------------------------------
  // Pointer and counter updates, all resolved at accept time.
  // A push and a tick never touch the same entry in overlapping cycles:
  // ticks only read published blocks, and a full ring refuses pushes.
  // --------------------------------------------------------------------------
  always_comb begin
    wr_blk_nxt   = wr_blk_r;
    rd_blk_nxt   = rd_blk_r;
    wr_pos_nxt   = wr_pos_r;
    rd_pos_nxt   = rd_pos_r;
    cnt_nxt      = cnt_r;
    underrun_nxt = underrun_r;
    if (do_write) begin
      if (wr_last) begin
        wr_pos_nxt = '0;
        wr_blk_nxt = (wr_blk_r == BLK_W'(RING_BLOCKS - 1)) ? '0 : wr_blk_r + 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
      end else begin
        wr_pos_nxt = wr_pos_r + 1'b1;
      end
    end
    if (do_read) begin
      if (rd_last) begin
        rd_pos_nxt = '0;
        rd_blk_nxt = (rd_blk_r == BLK_W'(RING_BLOCKS - 1)) ? '0 : rd_blk_r + 1'b1;
        cnt_nxt    = cnt_r - 1'b1;
      end else begin
        rd_pos_nxt = rd_pos_r + 1'b1;
      end
    end
    if (accept && is_tick && ring_empty && (underrun_r != 16'hFFFF)) begin
      underrun_nxt = underrun_r + 16'd1;
    end
  end

  // ready_blocks is the count masked to the 3-bit field.
  assign cnt_ext = 3'(cnt_nxt);

  always_comb begin
    s1_nxt.mode     = in_data.mode;
    s1_nxt.hit      = do_read;
    s1_nxt.wr_ok    = do_write;
    s1_nxt.done     = do_read && rd_last;
    s1_nxt.underrun = underrun_nxt;
    s1_nxt.ready    = cnt_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_blk_r   <= '0;
      rd_blk_r   <= '0;
      wr_pos_r   <= '0;
      rd_pos_r   <= '0;
      cnt_r      <= '0;
      underrun_r <= '0;
      gain_r     <= 4'd3;
    end else begin
      wr_blk_r   <= wr_blk_nxt;
      rd_blk_r   <= rd_blk_nxt;
      wr_pos_r   <= wr_pos_nxt;
      rd_pos_r   <= rd_pos_nxt;
      cnt_r      <= cnt_nxt;
      underrun_r <= underrun_nxt;
      if (cfg_we) begin
        gain_r <= cfg_wdata;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Ring memory
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (do_write) begin
      ring_mem[wr_addr] <= in_data.sample_value;
    end
  end

  // Read data holds until the next tick read, so a stalled stage 1 keeps it.
  always_ff @(posedge clk) begin
    if (do_read) begin
      rd_data_r <= ring_mem[rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Duty path: sample * gain, clamp to 16 bits signed, bias, keep top bits.
  // 16 x 4 bit product fits in 21 bits signed.
  // --------------------------------------------------------------------------
  logic signed [20:0]   samp_ext;
  logic signed [20:0]   gain_ext;
  logic signed [20:0]   amp;
  logic [15:0]          amp_sat;
  logic [15:0]          biased;
  logic [DUTY_BITS-1:0] duty_calc;
  logic [DUTY_BITS-1:0] duty_sel;

  assign samp_ext = {{5{rd_data_r[15]}}, rd_data_r};
  assign gain_ext = {17'd0, gain_r};
  assign amp      = samp_ext * gain_ext;

  always_comb begin
    if (amp > 21'sd32767) begin
      amp_sat = 16'h7FFF;
    end else if (amp < -21'sd32768) begin
      amp_sat = 16'h8000;
    end else begin
      amp_sat = amp[15:0];
    end
  end

  // Adding 32768 to a 16-bit signed value flips its sign bit.
  assign biased    = {~amp_sat[15], amp_sat[14:0]};
  assign duty_calc = biased[15 -: DUTY_BITS];

  always_comb begin
    if (s1_r.mode == MODE_PUSH) begin
      duty_sel = '0;
    end else if (s1_r.hit) begin
      duty_sel = duty_calc;
    end else begin
      duty_sel = DUTY_BITS'(1 << (DUTY_BITS - 1));   // underrun midpoint
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (out_free) begin
        s1_valid_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
    if (out_free && s1_valid_r) begin
      out_r.write_accepted <= s1_r.wr_ok;
      out_r.duty           <= duty_sel;
      out_r.duty_valid     <= (s1_r.mode == MODE_TICK);
      out_r.block_done     <= s1_r.done;
      out_r.underrun_count <= s1_r.underrun;
      out_r.ready_blocks   <= s1_r.ready;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(RING_BLOCKS))
    else $error("ready block count above ring size");

  a_accept_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted item not held in stage 1");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.write_accepted && out_r.duty_valid))
    else $error("result marked both push and tick");

  a_underrun_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (underrun_r >= $past(underrun_r)))
    else $error("underrun count went down");
`endif

endmodule
